FILE: design/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, register indexes, section codes and the item record that
// travels down the UV-sphere triangle index pipeline.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int TRI_W       = 21;
  localparam int IDX_W       = 21;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int Q_W         = TRI_W - 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  localparam int SLICE_RESET = 20;
  localparam int STACK_RESET = 20;
  localparam int SLICE_LOW   = 3;
  localparam int STACK_LOW   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 2'd1;

  typedef enum logic [1:0] {
    SEC_TOP,
    SEC_INNER,
    SEC_BOTTOM,
    SEC_OOR
  } section_t;

  typedef logic [IDX_W-1:0] index_t;

  typedef struct packed {
    section_t section;
    logic     odd;
    index_t   a;
    index_t   b;
    index_t   c;
  } item_t;

endpackage

FILE: design/uvs_cfg.sv
// ----------------------------------------------------------------------------
// uvs_cfg
// Slice and stack count registers with saturating writes.
// ----------------------------------------------------------------------------
module uvs_cfg #(
  parameter int MAX_SLICES = 1024,
  parameter int MAX_STACKS = 1024,
  parameter int SW         = 11,
  parameter int NW         = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]     cfg_data,
  output logic [SW-1:0]                 slice_count,
  output logic [NW-1:0]                 stack_count
);

  logic [SW-1:0] slice_next;
  logic [NW-1:0] stack_next;
  logic [31:0]   wide_data;

  assign cfg_ready = 1'b1;
  assign wide_data = 32'(cfg_data);

  always_comb begin
    if (wide_data < 32'(uvs_pkg::SLICE_LOW)) begin
      slice_next = SW'(uvs_pkg::SLICE_LOW);
    end else if (wide_data > 32'(MAX_SLICES)) begin
      slice_next = SW'(MAX_SLICES);
    end else begin
      slice_next = SW'(cfg_data);
    end
    if (wide_data < 32'(uvs_pkg::STACK_LOW)) begin
      stack_next = NW'(uvs_pkg::STACK_LOW);
    end else if (wide_data > 32'(MAX_STACKS)) begin
      stack_next = NW'(MAX_STACKS);
    end else begin
      stack_next = NW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count <= SW'(uvs_pkg::SLICE_RESET);
      stack_count <= NW'(uvs_pkg::STACK_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        uvs_pkg::REG_SLICE_COUNT: slice_count <= slice_next;
        uvs_pkg::REG_STACK_COUNT: stack_count <= stack_next;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_counts_floor: assert property (@(posedge clk) disable iff (rst)
    slice_count >= SW'(uvs_pkg::SLICE_LOW) && stack_count >= NW'(uvs_pkg::STACK_LOW))
    else $error("uvs_cfg: count below its floor");
`endif

endmodule

FILE: design/uvs_front.sv
// ----------------------------------------------------------------------------
// uvs_front
// Two stages: capture the triangle number with the S*(N-1) product, then
// sort it into top cap, inner stacks, bottom cap or out of range and form
// the cap indices and the quad number for the divider.
// ----------------------------------------------------------------------------
module uvs_front #(
  parameter int SW = 11,
  parameter int NW = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [uvs_pkg::TRI_W-1:0] in_tri,
  input  logic [SW-1:0]             slice_count,
  input  logic [NW-1:0]             stack_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output uvs_pkg::item_t            out_item,
  output logic [uvs_pkg::Q_W-1:0]   out_q
);

  localparam int PW = SW + NW;
  localparam int AW = ((PW + 1 > uvs_pkg::TRI_W) ? PW + 1 : uvs_pkg::TRI_W) + 1;

  logic                      v1;
  logic [uvs_pkg::TRI_W-1:0] t1;
  logic [PW-1:0]             sn1;
  logic                      en1;
  logic                      en2;

  logic [AW-1:0]             total;
  logic [AW-1:0]             t_w;
  logic [AW-1:0]             s_w;
  logic [AW-1:0]             n_w;
  logic [AW-1:0]             sn_w;
  logic [uvs_pkg::TRI_W-1:0] u;
  uvs_pkg::item_t            item_next;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1  <= in_tri;
      sn1 <= PW'(slice_count) * PW'(stack_count - NW'(1));
    end
  end

  assign total = AW'({sn1, 1'b0});
  assign t_w   = AW'(t1);
  assign s_w   = AW'(slice_count);
  assign n_w   = AW'(stack_count);
  assign sn_w  = AW'(sn1);
  assign u     = t1 - uvs_pkg::TRI_W'(slice_count);

  always_comb begin
    item_next.odd = u[0];
    item_next.a   = '0;
    item_next.b   = '0;
    item_next.c   = '0;
    if (t_w >= total) begin
      item_next.section = uvs_pkg::SEC_OOR;
    end else if (t_w < s_w) begin
      item_next.section = uvs_pkg::SEC_TOP;
      item_next.b       = uvs_pkg::IDX_W'(t_w + AW'(2));
      item_next.c       = uvs_pkg::IDX_W'(t_w + AW'(1));
    end else if (t_w < total - s_w) begin
      item_next.section = uvs_pkg::SEC_INNER;
    end else begin
      item_next.section = uvs_pkg::SEC_BOTTOM;
      item_next.a       = uvs_pkg::IDX_W'(sn_w + n_w);
      item_next.b       = uvs_pkg::IDX_W'(t_w + n_w - AW'(1) - sn_w);
      item_next.c       = uvs_pkg::IDX_W'(t_w + n_w - sn_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_item <= item_next;
      out_q    <= u[uvs_pkg::TRI_W-1:1];
    end
  end

endmodule

FILE: design/uvs_div_stage.sv
// ----------------------------------------------------------------------------
// uvs_div_stage
// One stage of the restoring divider that splits the quad number into
// ring and column: resolves quotient bits HI down to HI-NB+1.
// ----------------------------------------------------------------------------
module uvs_div_stage #(
  parameter int SW = 11,
  parameter int QW = 10,
  parameter int HI = 9,
  parameter int NB = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  uvs_pkg::item_t          in_item,
  input  logic [uvs_pkg::Q_W-1:0] in_rem,
  input  logic [QW-1:0]           in_quo,
  input  logic [SW-1:0]           slice_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output uvs_pkg::item_t          out_item,
  output logic [uvs_pkg::Q_W-1:0] out_rem,
  output logic [QW-1:0]           out_quo
);

  localparam int EW = ((uvs_pkg::Q_W > SW + QW) ? uvs_pkg::Q_W : SW + QW) + 1;
  localparam int LO = HI - NB + 1;

  logic          en;
  logic [EW-1:0] rem_w;
  logic [QW-1:0] quo_w;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [EW-1:0] d;
    rem_w = EW'(in_rem);
    quo_w = in_quo;
    for (int k = 0; k < NB; k++) begin
      d = EW'(slice_count) << (HI - k);
      if (rem_w >= d) begin
        rem_w         = rem_w - d;
        quo_w[HI - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_rem  <= uvs_pkg::Q_W'(rem_w);
      out_quo  <= quo_w;
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.section == uvs_pkg::SEC_INNER
      |-> EW'(out_rem) < (EW'(slice_count) << LO))
    else $error("uvs_div_stage: partial remainder out of bound");
`endif

endmodule

FILE: design/uvs_back.sv
// ----------------------------------------------------------------------------
// uvs_back
// Two stages: ring times row pitch, then the quad corners and the pick of
// the triangle, held in the output register.
// ----------------------------------------------------------------------------
module uvs_back #(
  parameter int SW = 11,
  parameter int QW = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  uvs_pkg::item_t          in_item,
  input  logic [uvs_pkg::Q_W-1:0] in_rem,
  input  logic [QW-1:0]           in_quo,
  input  logic [SW-1:0]           slice_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output uvs_pkg::index_t         index_a,
  output uvs_pkg::index_t         index_b,
  output uvs_pkg::index_t         index_c,
  output logic                    out_of_range
);

  localparam int MW = QW + SW + 1;

  logic            v1;
  uvs_pkg::item_t  item1;
  logic [MW-1:0]   prod1;
  logic [SW-1:0]   col1;
  logic            en1;
  logic            en2;

  uvs_pkg::index_t pitch;
  uvs_pkg::index_t up;
  uvs_pkg::index_t dn;
  uvs_pkg::index_t a_next;
  uvs_pkg::index_t b_next;
  uvs_pkg::index_t c_next;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item1 <= in_item;
      prod1 <= MW'(in_quo) * (MW'(slice_count) + MW'(1));
      col1  <= in_rem[SW-1:0];
    end
  end

  assign pitch = uvs_pkg::IDX_W'(slice_count) + uvs_pkg::IDX_W'(1);
  assign up    = uvs_pkg::IDX_W'(1) + uvs_pkg::IDX_W'(prod1) + uvs_pkg::IDX_W'(col1);
  assign dn    = up + pitch;

  always_comb begin
    case (item1.section)
      uvs_pkg::SEC_INNER: begin
        if (item1.odd) begin
          a_next = dn;
          b_next = up + uvs_pkg::IDX_W'(1);
          c_next = dn + uvs_pkg::IDX_W'(1);
        end else begin
          a_next = up;
          b_next = up + uvs_pkg::IDX_W'(1);
          c_next = dn;
        end
      end
      default: begin
        a_next = item1.a;
        b_next = item1.b;
        c_next = item1.c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      index_a      <= a_next;
      index_b      <= b_next;
      index_c      <= c_next;
      out_of_range <= (item1.section == uvs_pkg::SEC_OOR);
    end
  end

`ifndef SYNTH
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> index_a == '0 && index_b == '0 && index_c == '0)
    else $error("uvs_back: out of range word carries nonzero indices");
  a_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> index_a != index_c && index_b != index_c)
    else $error("uvs_back: degenerate triangle");
`endif

endmodule

FILE: design/uv_sphere_triangle_indices.sv
// Throughput: one word per clock while m_axis_tready is high; the
//   ring/column divider resolves up to two quotient bits per pipeline
//   stage, which sets the depth.
// Reset: slice_count and stack_count return to 20, all stages empty.
// ----------------------------------------------------------------------------
// uv_sphere_triangle_indices
// Maps a triangle number of a latitude-longitude sphere to its three vertex
// indices, with an out-of-range flag past the last triangle.
// ----------------------------------------------------------------------------
module uv_sphere_triangle_indices #(
  parameter int MAX_SLICES = 1024,
  parameter int MAX_STACKS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [20:0] triangle_number
  input  logic [uvs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [20:0] index_a, [41:21] index_b, [62:42] index_c
  output logic [uvs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] out_of_range
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uvs_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SW  = $clog2(((MAX_SLICES > uvs_pkg::SLICE_RESET) ?
                                MAX_SLICES : uvs_pkg::SLICE_RESET) + 1);
  localparam int NW  = $clog2(((MAX_STACKS > uvs_pkg::STACK_RESET) ?
                                MAX_STACKS : uvs_pkg::STACK_RESET) + 1);
  localparam int QW  = $clog2(MAX_STACKS);
  localparam int NDS = (QW + 1) / 2;

  logic [SW-1:0]            slice_count;
  logic [NW-1:0]            stack_count;

  logic                     dv   [NDS+1];
  logic                     drdy [NDS+1];
  uvs_pkg::item_t           ditem[NDS+1];
  logic [uvs_pkg::Q_W-1:0]  drem [NDS+1];
  logic [QW-1:0]            dquo [NDS+1];

  uvs_pkg::index_t          index_a;
  uvs_pkg::index_t          index_b;
  uvs_pkg::index_t          index_c;

  uvs_cfg #(
    .MAX_SLICES (MAX_SLICES),
    .MAX_STACKS (MAX_STACKS),
    .SW         (SW),
    .NW         (NW)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .slice_count (slice_count),
    .stack_count (stack_count)
  );

  uvs_front #(
    .SW (SW),
    .NW (NW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_tri      (s_axis_tdata[uvs_pkg::TRI_W-1:0]),
    .slice_count (slice_count),
    .stack_count (stack_count),
    .out_valid   (dv[0]),
    .out_ready   (drdy[0]),
    .out_item    (ditem[0]),
    .out_q       (drem[0])
  );

  assign dquo[0] = '0;

  for (genvar g = 0; g < NDS; g++) begin : g_div
    localparam int HI = QW - 1 - 2 * g;
    localparam int NB = (HI >= 1) ? 2 : 1;

    uvs_div_stage #(
      .SW (SW),
      .QW (QW),
      .HI (HI),
      .NB (NB)
    ) u_div (
      .clk         (clk),
      .rst         (rst),
      .in_valid    (dv[g]),
      .in_ready    (drdy[g]),
      .in_item     (ditem[g]),
      .in_rem      (drem[g]),
      .in_quo      (dquo[g]),
      .slice_count (slice_count),
      .out_valid   (dv[g+1]),
      .out_ready   (drdy[g+1]),
      .out_item    (ditem[g+1]),
      .out_rem     (drem[g+1]),
      .out_quo     (dquo[g+1])
    );
  end

  uvs_back #(
    .SW (SW),
    .QW (QW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dv[NDS]),
    .in_ready     (drdy[NDS]),
    .in_item      (ditem[NDS]),
    .in_rem       (drem[NDS]),
    .in_quo       (dquo[NDS]),
    .slice_count  (slice_count),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .index_a      (index_a),
    .index_b      (index_b),
    .index_c      (index_c),
    .out_of_range (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, index_c, index_b, index_a};

endmodule
